[rtl/htb_pkg.sv]
package htb_pkg;

    localparam int MaxLeaves = 16;
    localparam int NodeDepth = 2 * MaxLeaves - 1;
    localparam int IdxW      = $clog2(NodeDepth);
    localparam int CntW      = $clog2(MaxLeaves + 1);
    localparam int WeightW   = 20;
    localparam int LinkW     = 6;
    localparam int LeafW     = 16;

    localparam logic [LinkW-1:0] NoNode = '1;

    // leaf beat passed from the front end to the builder
    typedef struct packed {
        logic [LeafW-1:0] weight;
        logic             last;
    } leaf_beat_t;

    // one node record on the result side
    typedef struct packed {
        logic [IdxW-1:0]    index;
        logic [WeightW-1:0] weight;
        logic [LinkW-1:0]   parent;
        logic [LinkW-1:0]   left;
        logic [LinkW-1:0]   right;
        logic               last;
    } node_rec_t;

endpackage

[rtl/htb_front.sv]
module htb_front
    import htb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  leaf_beat_t in_beat,
    output logic       q_valid,
    input  logic       q_ready,
    output leaf_beat_t q_beat
);

    // two-entry queue decoupling the stream input from the builder
    leaf_beat_t mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_beat   = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_beat;
    end

endmodule

[rtl/htb_back.sv]
module htb_back
    import htb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    output logic       q_ready,
    input  leaf_beat_t q_beat,
    output logic       out_valid,
    input  logic       out_ready,
    output node_rec_t  out_rec
);

    typedef enum logic [2:0] {
        S_LOAD, S_INIT, S_SCAN, S_LINK, S_EMIT, S_WAIT
    } state_t;

    // node table held in flops: the link step reads and writes several entries at once
    logic [WeightW-1:0] wt_reg  [NodeDepth];
    logic [LinkW-1:0]   par_reg [NodeDepth];
    logic [LinkW-1:0]   lft_reg [NodeDepth];
    logic [LinkW-1:0]   rgt_reg [NodeDepth];

    state_t             state_reg;
    logic [CntW-1:0]    cnt_reg;
    logic [IdxW-1:0]    node_reg;     // internal node being built
    logic [IdxW-1:0]    total_reg;    // last node index
    logic [IdxW-1:0]    scan_reg;
    logic               second_reg;
    logic               found_reg;
    logic [IdxW-1:0]    best_reg;
    logic [WeightW-1:0] bestw_reg;
    logic [IdxW-1:0]    m1_reg;
    logic [IdxW-1:0]    emit_reg;
    node_rec_t          rec_reg;
    logic               ov_reg;

    logic               take;
    logic               better;

    assign q_ready   = (state_reg == S_LOAD);
    assign take      = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign out_rec   = rec_reg;
    assign better    = (par_reg[scan_reg] == NoNode)
                       && (!found_reg || wt_reg[scan_reg] < bestw_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            cnt_reg    <= '0;
            ov_reg     <= 1'b0;
            node_reg   <= '0;
            total_reg  <= '0;
            scan_reg   <= '0;
            second_reg <= 1'b0;
            found_reg  <= 1'b0;
            best_reg   <= '0;
            m1_reg     <= '0;
            emit_reg   <= '0;
        end
        else
        begin
            // in emit the record register is refilled whenever it drains
            if (ov_reg && out_ready && state_reg != S_EMIT)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (take)
                    begin
                        if (cnt_reg < CntW'(MaxLeaves))
                            cnt_reg <= cnt_reg + 1'b1;
                        if (q_beat.last)
                            state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    node_reg   <= IdxW'(cnt_reg);
                    total_reg  <= IdxW'({cnt_reg, 1'b0} - 2);
                    scan_reg   <= '0;
                    second_reg <= 1'b0;
                    found_reg  <= 1'b0;
                    best_reg   <= '0;
                    emit_reg   <= '0;
                    state_reg  <= (cnt_reg == CntW'(1)) ? S_EMIT : S_SCAN;
                end
                S_SCAN:
                begin
                    if (better)
                    begin
                        found_reg <= 1'b1;
                        best_reg  <= scan_reg;
                        bestw_reg <= wt_reg[scan_reg];
                    end
                    if (scan_reg + 1'b1 == node_reg)
                        state_reg <= S_LINK;
                    else
                        scan_reg <= scan_reg + 1'b1;
                end
                S_LINK:
                begin
                    scan_reg  <= '0;
                    found_reg <= 1'b0;
                    best_reg  <= '0;
                    if (!second_reg)
                    begin
                        m1_reg     <= best_reg;
                        second_reg <= 1'b1;
                        state_reg  <= S_SCAN;
                    end
                    else
                    begin
                        second_reg <= 1'b0;
                        if (node_reg == total_reg)
                            state_reg <= S_EMIT;
                        else
                        begin
                            node_reg  <= node_reg + 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        ov_reg         <= 1'b1;
                        rec_reg.index  <= emit_reg;
                        rec_reg.weight <= wt_reg[emit_reg];
                        rec_reg.parent <= par_reg[emit_reg];
                        rec_reg.left   <= lft_reg[emit_reg];
                        rec_reg.right  <= rgt_reg[emit_reg];
                        rec_reg.last   <= (emit_reg == total_reg);
                        if (emit_reg == total_reg)
                            state_reg <= S_WAIT;
                        else
                            emit_reg <= emit_reg + 1'b1;
                    end
                end
                S_WAIT:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    // table writes
    always_ff @(posedge clk)
    begin
        if (take && cnt_reg < CntW'(MaxLeaves))
        begin
            wt_reg[IdxW'(cnt_reg)]  <= WeightW'(q_beat.weight);
            par_reg[IdxW'(cnt_reg)] <= NoNode;
            lft_reg[IdxW'(cnt_reg)] <= NoNode;
            rgt_reg[IdxW'(cnt_reg)] <= NoNode;
        end
        if (state_reg == S_INIT)
            par_reg[IdxW'(cnt_reg)] <= NoNode;
        if (state_reg == S_LINK)
        begin
            par_reg[best_reg] <= LinkW'(node_reg);
            if (second_reg)
            begin
                wt_reg[node_reg]  <= wt_reg[m1_reg] + wt_reg[best_reg];
                lft_reg[node_reg] <= LinkW'(m1_reg);
                rgt_reg[node_reg] <= LinkW'(best_reg);
                if (node_reg != total_reg)
                    par_reg[node_reg + 1'b1] <= NoNode;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> !q_ready)
        else $error("queue popped outside load");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(MaxLeaves))
        else $error("leaf count overflow");
    a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> (ov_reg && $stable(rec_reg)))
        else $error("stalled record changed");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_reg < node_reg))
        else $error("scan past build node");
`endif

endmodule

[rtl/huffman_tree_builder.sv]
// Huffman tree builder. Leaf weights stream in one beat each; the beat with
// tlast closes the set (up to 16 leaves, extras dropped) and the block builds
// the tree in a 2n-1 node table, then streams one beat per node in index
// order with tlast on the final node. Each internal node is built by two
// linear scans over the nodes below it, each followed by a link step, after
// one setup step for the set. Leaves load through a two-entry input queue;
// the builder takes none from it while a tree is built or emitted, but the
// queue still accepts two. Links of -1 read as all ones in 6 bits.
module huffman_tree_builder
    import htb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // leaf_weight[15:0]
    input  logic        s_tlast,   // last_leaf
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // node_index[4:0], node_weight[24:5],
                                   // parent_index[30:25], left_index[36:31],
                                   // right_index[42:37], zero fill
    output logic        m_tlast    // last_node
);

    leaf_beat_t in_beat, q_beat;
    logic       q_valid, q_ready;
    node_rec_t  rec;

    assign in_beat.weight = s_tdata;
    assign in_beat.last   = s_tlast;

    htb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_beat  (in_beat),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_beat   (q_beat)
    );

    htb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_beat    (q_beat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (rec)
    );

    assign m_tdata = {5'd0, rec.right, rec.left, rec.parent, rec.weight, rec.index};
    assign m_tlast = rec.last;

endmodule

[tb/sv/huffman_tree_builder_tb.sv]
`timescale 1ns / 100ps

module huffman_tree_builder_tb;
    import htb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // leaf_weight[15:0]
    logic        s_tlast;   // last_leaf
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // node_index, node_weight, parent, left, right, zero fill
    logic        m_tlast;   // last_node

    huffman_tree_builder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // leaf beats waiting for the driver, node records waiting for the monitor
    leaf_beat_t leaf_queue[$];
    node_rec_t  node_expected[$];
    int         fail_count = 0;
    bit         stim_done = 0;
    int         cyc = 0;
    bit         s_tready_seen = 0;

    // predictor's own copy of the node table
    logic [WeightW-1:0] tw [NodeDepth];
    logic [LinkW-1:0]   tp [NodeDepth];
    logic [LinkW-1:0]   tl [NodeDepth];
    logic [LinkW-1:0]   tr [NodeDepth];
    int                 held = 0;

    function automatic int least_parentless(int limit);
        int best;
        best = -1;
        for (int j = 0; j < limit; j++)
        begin
            if (tp[j] == NoNode && (best < 0 || tw[j] < tw[best]))
                best = j;
        end
        return (best < 0) ? 0 : best;
    endfunction

    // absorb one accepted leaf; on the final leaf build the tree and queue records
    task automatic predict_tree(leaf_beat_t b);
        int n;
        int total;
        int m1;
        int m2;
        node_rec_t rec;
        if (held < MaxLeaves)
        begin
            tw[held] = WeightW'(b.weight);
            tp[held] = NoNode;
            tl[held] = NoNode;
            tr[held] = NoNode;
            held++;
        end
        if (b.last)
        begin
            n = held;
            total = 2 * n - 1;
            for (int i = n; i < total; i++)
            begin
                tp[i] = NoNode;
                m1 = least_parentless(i);
                tp[m1] = LinkW'(i);
                m2 = least_parentless(i);
                tp[m2] = LinkW'(i);
                tw[i] = tw[m1] + tw[m2];
                tl[i] = LinkW'(m1);
                tr[i] = LinkW'(m2);
            end
            for (int i = 0; i < total; i++)
            begin
                rec.index  = IdxW'(i);
                rec.weight = tw[i];
                rec.parent = tp[i];
                rec.left   = tl[i];
                rec.right  = tr[i];
                rec.last   = (i == total - 1);
                node_expected.push_back(rec);
            end
            held = 0;
        end
    endtask

    // random idling, off for a long stretch in the middle of the run
    function automatic bit idle_now();
        if (cyc > 6000 && cyc < 14000)
            return 1'b0;
        return $urandom_range(99) < 17;
    endfunction

    // driver: change inputs at the falling edge, one nba per signal per step
    always @(negedge clk)
    begin
        cyc <= cyc + 1;
        if (rst_n)
        begin
            if (!s_tvalid || s_tready_seen)
            begin
                if (leaf_queue.size() != 0 && !idle_now())
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= leaf_queue[0].weight;
                    s_tlast  <= leaf_queue[0].last;
                    void'(leaf_queue.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !idle_now();
        end
    end

    // handshake on the input side, sampled at the rising edge
    always @(posedge clk)
    begin
        leaf_beat_t b;
        s_tready_seen = 0;
        if (rst_n && s_tvalid && s_tready)
        begin
            s_tready_seen = 1;
            b.weight = s_tdata;
            b.last   = s_tlast;
            predict_tree(b);
        end
    end

    // monitor: compare each accepted node beat with the oldest expectation
    always @(posedge clk)
    begin
        node_rec_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (node_expected.size() == 0)
            begin
                $error("node beat with nothing expected: tdata=%h", m_tdata);
                fail_count++;
            end
            else
            begin
                e = node_expected.pop_front();
                if (m_tdata[4:0] !== e.index)
                begin
                    $error("node_index exp %0d got %0d", e.index, m_tdata[4:0]);
                    fail_count++;
                end
                if (m_tdata[24:5] !== e.weight)
                begin
                    $error("node_weight exp %0d got %0d", e.weight, m_tdata[24:5]);
                    fail_count++;
                end
                if (m_tdata[30:25] !== e.parent)
                begin
                    $error("parent_index exp %0d got %0d", e.parent, m_tdata[30:25]);
                    fail_count++;
                end
                if (m_tdata[36:31] !== e.left)
                begin
                    $error("left_index exp %0d got %0d", e.left, m_tdata[36:31]);
                    fail_count++;
                end
                if (m_tdata[42:37] !== e.right)
                begin
                    $error("right_index exp %0d got %0d", e.right, m_tdata[42:37]);
                    fail_count++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last_node exp %0d got %0d", e.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    task automatic push_leaf(logic [15:0] w, logic l);
        leaf_beat_t b;
        b.weight = w;
        b.last   = l;
        leaf_queue.push_back(b);
    endtask

    // weight picker: mix extremes, small values (many ties) and full range
    function automatic logic [15:0] pick_weight();
        case ($urandom_range(3))
            0: return $urandom_range(3) == 0 ? 16'h0000 : 16'hffff;
            1: return 16'($urandom_range(4));
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int sz;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: single leaves at both extremes, two leaves at extremes, all ties
        push_leaf(16'h0000, 1'b1);
        push_leaf(16'hffff, 1'b1);
        push_leaf(16'hffff, 1'b0);
        push_leaf(16'h0000, 1'b1);
        for (int i = 0; i < 3; i++)
            push_leaf(16'h0005, i == 2);
        // overflow: 18 leaves, the last two dropped, final one still starts the build
        for (int i = 0; i < 18; i++)
            push_leaf(16'hffff - 16'(i), i == 17);

        // random sets, mostly small, a few full or overflowing
        for (int k = 0; k < 255; k += sz)
        begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 6);
            for (int i = 0; i < sz; i++)
                push_leaf(pick_weight(), i == sz - 1);
        end

        wait (leaf_queue.size() == 0 && !s_tvalid);
        wait (node_expected.size() == 0);
        repeat (400) @(posedge clk);
        if (fail_count == 0 && node_expected.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
rtl/htb_pkg.sv
rtl/htb_front.sv
rtl/htb_back.sv
rtl/huffman_tree_builder.sv
tb/sv/huffman_tree_builder_tb.sv
